// ===== src/nbit_color_error_diffusion_top_assert.svh =====
`ifndef NBIT_COLOR_ERROR_DIFFUSION_TOP_ASSERT_SVH
`define NBIT_COLOR_ERROR_DIFFUSION_TOP_ASSERT_SVH

// checks clocked on clk, off while arst_n is low
`define NCD_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("ncd: forbidden condition seen");

`define NCD_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ncd: implication failed");

`define NCD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ncd: next-cycle implication failed");

`endif

// ===== src/ncd_pkg.sv =====
`timescale 1ns / 1ps

package ncd_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int ERROR_BITS   = 10;
	localparam int COL_BITS     = $clog2(MAX_WIDTH);
	localparam int WIDTH_BITS   = 11;
	localparam int SHIFT_BITS   = 4;
	localparam int MAX_SHIFT    = 8;
	localparam int CFG_BITS     = 11;
	localparam int CFG_IDX_BITS = 1;
	localparam int PIX_BITS     = 8;
	localparam int NUM_CHAN     = 3;
	localparam int ROW_BITS     = NUM_CHAN * ERROR_BITS;
	localparam int WEIGHT_SHIFT = 4;
	localparam int CALC_BITS    = (ERROR_BITS > 9 ? ERROR_BITS : 9) + 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_COUNT = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH  = CFG_IDX_BITS'(1);

	localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = SHIFT_BITS'(4);
	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(640);

	localparam logic signed [CALC_BITS-1:0] ERR_HI = CALC_BITS'(2 ** (ERROR_BITS - 1) - 1);
	localparam logic signed [CALC_BITS-1:0] ERR_LO = -ERR_HI - CALC_BITS'(1);

	typedef logic signed [ERROR_BITS-1:0] err_t;
	typedef logic signed [CALC_BITS-1:0] calc_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] red;
		logic [PIX_BITS-1:0] green;
		logic [PIX_BITS-1:0] blue;
		logic                frame_start;
	} px_in_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] red_out;
		logic [PIX_BITS-1:0] green_out;
		logic [PIX_BITS-1:0] blue_out;
	} px_out_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] level_pix;
		err_t                down_left;
		err_t                new_left;
		err_t                new_center;
		err_t                new_right;
	} chan_res_t;

	function automatic err_t err_sat(input calc_t v);
		err_t r;
		if (v > ERR_HI) begin
			r = ERR_HI[ERROR_BITS-1:0];
		end else if (v < ERR_LO) begin
			r = ERR_LO[ERROR_BITS-1:0];
		end else begin
			r = v[ERROR_BITS-1:0];
		end
		return r;
	endfunction

	// divide by 16, truncating toward zero
	function automatic calc_t div16(input calc_t v);
		calc_t b;
		b = v + (v[CALC_BITS-1] ? calc_t'((1 << WEIGHT_SHIFT) - 1) : calc_t'(0));
		return b >>> WEIGHT_SHIFT;
	endfunction

	function automatic chan_res_t chan_calc(
		input logic [PIX_BITS-1:0]   pix,
		input err_t                  carry,
		input err_t                  above,
		input logic                  use_above,
		input err_t                  pend_l,
		input err_t                  pend_c,
		input logic [SHIFT_BITS-1:0] sh
	);
		calc_t                 want, level, e, e3, e5, e7;
		logic [CALC_BITS-1:0]  mag, lvl_mag, mask;
		chan_res_t             r;
		want = $signed(CALC_BITS'(pix)) + calc_t'(carry)
			+ (use_above ? calc_t'(above) : calc_t'(0));
		mag = want[CALC_BITS-1] ? CALC_BITS'(-want) : CALC_BITS'(want);
		mask = {CALC_BITS{1'b1}} << sh;
		lvl_mag = mag & mask;
		level = want[CALC_BITS-1] ? -$signed(lvl_mag) : $signed(lvl_mag);
		e = want - level;
		e3 = (e <<< 1) + e;
		e5 = (e <<< 2) + e;
		e7 = (e <<< 3) - e;
		if (level[CALC_BITS-1]) begin
			r.level_pix = '0;
		end else if (level > calc_t'(255)) begin
			r.level_pix = '1;
		end else begin
			r.level_pix = level[PIX_BITS-1:0];
		end
		r.down_left  = err_sat(calc_t'(pend_l) + div16(e3));
		r.new_left   = err_sat(calc_t'(pend_c) + div16(e5));
		r.new_center = err_sat(div16(e));
		r.new_right  = err_sat(div16(e7));
		return r;
	endfunction

endpackage

// ===== src/nbit_color_error_diffusion_top.sv =====
`timescale 1ns / 1ps

// Floyd-Steinberg color dithering on a raster RGB stream, one pixel per clock
// sustained while out_ready stays high. Each pixel passes two registers: the
// input register, where the line store read for the pixel's column lands, and
// the result register. The line store is a 1024 x 30 single-write-port RAM; a
// row end needs two entries written, so the own-column entry is held in a write
// buffer until the port is free, with forwarding on reads. The store is not
// cleared at reset: the first row after reset or frame_start never reads it.
// Configuration writes land at once and are meant for idle periods.
module nbit_color_error_diffusion_top
	import ncd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  px_in_t                  in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output px_out_t                 out_data,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	logic [SHIFT_BITS-1:0] shift_q;
	logic [WIDTH_BITS-1:0] width_q;
	logic [SHIFT_BITS-1:0] sh;
	logic [COL_BITS-1:0]   w_m1;

	logic [COL_BITS-1:0] col_q;
	logic                first_q;
	logic [COL_BITS-1:0] col_start;
	logic [COL_BITS-1:0] x_in;
	logic                last_in;
	logic                first_in;
	logic                in_acc;

	logic                valid_s1;
	px_in_t              px_s1;
	logic [COL_BITS-1:0] x_s1;
	logic                last_s1;
	logic                first_s1;
	logic [ROW_BITS-1:0] mem_rd_s1;
	logic                fwd_hit_s1;
	logic [ROW_BITS-1:0] fwd_data_s1;
	logic                s1_adv;

	logic [ROW_BITS-1:0] row_err_q [MAX_WIDTH];
	logic                mem_we;
	logic [COL_BITS-1:0] mem_waddr;
	logic [ROW_BITS-1:0] mem_wdata;

	logic                wb_valid_q;
	logic [COL_BITS-1:0] wb_addr_q;
	logic [ROW_BITS-1:0] wb_data_q;
	logic                wb_load;
	logic                wb_drain;

	err_t carry_q [NUM_CHAN];
	err_t pend_l_q [NUM_CHAN];
	err_t pend_c_q [NUM_CHAN];

	logic [PIX_BITS-1:0] pix [NUM_CHAN];
	chan_res_t           res [NUM_CHAN];
	logic [ROW_BITS-1:0] rd_s1;
	logic [ROW_BITS-1:0] wr_a_data;
	logic [ROW_BITS-1:0] wr_b_data;
	logic [COL_BITS-1:0] x_left;
	logic                wr_a;
	logic                wr_b;
	logic                fwd_hit;
	logic [ROW_BITS-1:0] fwd_data;

	logic    out_valid_q;
	px_out_t out_data_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SHIFT_RESET;
			width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHIFT_COUNT: shift_q <= cfg_data[SHIFT_BITS-1:0];
				REG_LINE_WIDTH:  width_q <= cfg_data[WIDTH_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sh = (shift_q > SHIFT_BITS'(MAX_SHIFT)) ? SHIFT_BITS'(MAX_SHIFT) : shift_q;
		if (width_q == '0) begin
			w_m1 = '0;
		end else if (width_q > WIDTH_BITS'(MAX_WIDTH)) begin
			w_m1 = COL_BITS'(MAX_WIDTH - 1);
		end else begin
			w_m1 = COL_BITS'(width_q - WIDTH_BITS'(1));
		end
	end

	// column tracking on the input side
	assign in_ready  = !valid_s1 || s1_adv;
	assign in_acc    = in_valid && in_ready;
	assign col_start = in_data.frame_start ? '0 : col_q;
	assign x_in      = (col_start > w_m1) ? w_m1 : col_start;
	assign last_in   = (x_in == w_m1);
	assign first_in  = in_data.frame_start || first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
		end else if (in_acc) begin
			col_q   <= last_in ? '0 : COL_BITS'(x_in + COL_BITS'(1));
			first_q <= last_in ? 1'b0 : first_in;
		end
	end

	// stage 1: pixel plus line-store word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1       <= in_data;
			x_s1        <= x_in;
			last_s1     <= last_in;
			first_s1    <= first_in;
			fwd_hit_s1  <= fwd_hit;
			fwd_data_s1 <= fwd_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			row_err_q[mem_waddr] <= mem_wdata;
		end
		if (in_acc) begin
			mem_rd_s1 <= row_err_q[x_in];
		end
	end

	assign s1_adv = valid_s1 && (!out_valid_q || out_ready);
	assign rd_s1  = fwd_hit_s1 ? fwd_data_s1 : mem_rd_s1;
	assign pix[0] = px_s1.red;
	assign pix[1] = px_s1.green;
	assign pix[2] = px_s1.blue;

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			res[c] = chan_calc(pix[c],
				px_s1.frame_start ? err_t'(0) : carry_q[c],
				$signed(rd_s1[c*ERROR_BITS +: ERROR_BITS]),
				!first_s1,
				px_s1.frame_start ? err_t'(0) : pend_l_q[c],
				px_s1.frame_start ? err_t'(0) : pend_c_q[c],
				sh);
			wr_a_data[c*ERROR_BITS +: ERROR_BITS] = res[c].down_left;
			wr_b_data[c*ERROR_BITS +: ERROR_BITS] = res[c].new_left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				carry_q[c]  <= '0;
				pend_l_q[c] <= '0;
				pend_c_q[c] <= '0;
			end
		end else if (s1_adv) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				if (last_s1) begin
					carry_q[c]  <= '0;
					pend_l_q[c] <= '0;
					pend_c_q[c] <= '0;
				end else begin
					carry_q[c]  <= res[c].new_right;
					pend_l_q[c] <= res[c].new_left;
					pend_c_q[c] <= res[c].new_center;
				end
			end
		end
	end

	// line-store writes: left neighbor for every pixel but column 0, own column at row end
	assign x_left   = COL_BITS'(x_s1 - COL_BITS'(1));
	assign wr_a     = s1_adv && (x_s1 != '0);
	assign wr_b     = s1_adv && last_s1;
	assign wb_load  = wr_b && (wr_a || wb_valid_q);
	assign wb_drain = wb_valid_q && !wr_a;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = x_s1;
		mem_wdata = wr_b_data;
		if (wr_a) begin
			mem_we    = 1'b1;
			mem_waddr = x_left;
			mem_wdata = wr_a_data;
		end else if (wb_valid_q) begin
			mem_we    = 1'b1;
			mem_waddr = wb_addr_q;
			mem_wdata = wb_data_q;
		end else if (wr_b) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_q <= 1'b0;
		end else if (wb_load) begin
			wb_valid_q <= 1'b1;
		end else if (wb_drain) begin
			wb_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_load) begin
			wb_addr_q <= x_s1;
			wb_data_q <= wr_b_data;
		end
	end

	// read bypass: writes landing at the read edge, then the buffered word
	always_comb begin
		fwd_hit  = 1'b0;
		fwd_data = wb_data_q;
		if (wr_a && x_left == x_in) begin
			fwd_hit  = 1'b1;
			fwd_data = wr_a_data;
		end else if (wr_b && x_s1 == x_in) begin
			fwd_hit  = 1'b1;
			fwd_data = wr_b_data;
		end else if (wb_valid_q && wb_addr_q == x_in) begin
			fwd_hit = 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q.red_out   <= res[0].level_pix;
			out_data_q.green_out <= res[1].level_pix;
			out_data_q.blue_out  <= res[2].level_pix;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`include "nbit_color_error_diffusion_top_assert.svh"

	`NCD_ASSERT_NEVER(a_wb_port_clash, wb_valid_q && wr_a)
	`NCD_ASSERT_NEXT(a_wb_drains, wb_valid_q && !wr_b, !wb_valid_q)
	`NCD_ASSERT_IMPLY(a_out_from_s1, $rose(out_valid_q), $past(s1_adv))

endmodule

// ===== dv/nbit_color_error_diffusion_top_test.sv =====
`timescale 1ns / 1ps

module nbit_color_error_diffusion_top_test;
	import ncd_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	px_in_t                  in_data = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	px_out_t                 out_data;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0]     cfg_data = '0;

	nbit_color_error_diffusion_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	px_in_t  pixel_q[$];
	px_out_t dithered_q[$];
	px_out_t want_px;

	// dither state and shadow registers
	int next_row_err [MAX_WIDTH][NUM_CHAN];
	int carry_err [NUM_CHAN];
	int left_err [NUM_CHAN];
	int center_err [NUM_CHAN];
	int col = 0;
	bit top_row = 1'b1;
	int step_log2 = 4;
	int row_len = 640;

	int gen_width = 640;
	bit fresh_frame = 1'b0;
	int gap_max = 0;
	int stall_pct = 0;
	int gap_cnt = 0;
	int burst_cnt = 0;
	int ready_run = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;

	function automatic int eff_width(input int v);
		if (v < 1) return 1;
		if (v > MAX_WIDTH) return MAX_WIDTH;
		return v;
	endfunction

	function automatic int clamp_err(input int v);
		int hi;
		int lo;
		hi = (1 << (ERROR_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic px_out_t dither_pixel(input px_in_t px);
		int sh, stp, w, x, want, lvl, e;
		bit last;
		int pix [NUM_CHAN];
		int o [NUM_CHAN];
		px_out_t r;
		sh = (step_log2 > MAX_SHIFT) ? MAX_SHIFT : step_log2;
		stp = 1 << sh;
		w = eff_width(row_len);
		if (px.frame_start) begin
			col = 0;
			top_row = 1'b1;
			for (int c = 0; c < NUM_CHAN; c++) begin
				carry_err[c] = 0;
				left_err[c] = 0;
				center_err[c] = 0;
			end
		end
		x = (col >= w) ? w - 1 : col;
		last = (x + 1 >= w);
		pix[0] = int'(px.red);
		pix[1] = int'(px.green);
		pix[2] = int'(px.blue);
		for (int c = 0; c < NUM_CHAN; c++) begin
			want = pix[c] + carry_err[c];
			if (!top_row)
				want = want + next_row_err[x][c];
			lvl = (want / stp) * stp;
			e = want - lvl;
			o[c] = (lvl < 0) ? 0 : ((lvl > 255) ? 255 : lvl);
			if (x > 0)
				next_row_err[x-1][c] = clamp_err(left_err[c] + (3 * e) / 16);
			left_err[c] = clamp_err(center_err[c] + (5 * e) / 16);
			if (last) begin
				next_row_err[x][c] = left_err[c];
				left_err[c] = 0;
				center_err[c] = 0;
				carry_err[c] = 0;
			end else begin
				center_err[c] = clamp_err(e / 16);
				carry_err[c] = clamp_err((7 * e) / 16);
			end
		end
		if (last) begin
			col = 0;
			top_row = 1'b0;
		end else begin
			col = (x + 1) & (MAX_WIDTH - 1);
		end
		r.red_out = 8'(o[0]);
		r.green_out = 8'(o[1]);
		r.blue_out = 8'(o[2]);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_cnt <= 0;
			burst_cnt <= 0;
		end else begin
			if (in_valid && in_ready)
				dithered_q.insert(dithered_q.size(), dither_pixel(in_data));
			if (!in_valid || in_ready) begin
				if (gap_cnt != 0) begin
					in_valid <= 1'b0;
					gap_cnt <= gap_cnt - 1;
				end else if (pixel_q.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= pixel_q.pop_front();
					if (burst_cnt > 1) begin
						burst_cnt <= burst_cnt - 1;
					end else begin
						burst_cnt <= $urandom_range(16, 1);
						gap_cnt <= (gap_max == 0) ? 0 : $urandom_range(gap_max, 1);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (ready_run == 0) begin
				out_ready <= ($urandom_range(99) >= stall_pct);
				ready_run <= $urandom_range(6, 1);
			end else begin
				ready_run <= ready_run - 1;
			end
			if (out_valid && out_ready) begin
				if (dithered_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h", $time, out_data);
					mismatch_cnt++;
				end else begin
					want_px = dithered_q.pop_front();
					if (out_data.red_out !== want_px.red_out) begin
						$display("%0t: red_out expected %0d actual %0d",
							$time, want_px.red_out, out_data.red_out);
						mismatch_cnt++;
					end
					if (out_data.green_out !== want_px.green_out) begin
						$display("%0t: green_out expected %0d actual %0d",
							$time, want_px.green_out, out_data.green_out);
						mismatch_cnt++;
					end
					if (out_data.blue_out !== want_px.blue_out) begin
						$display("%0t: blue_out expected %0d actual %0d",
							$time, want_px.blue_out, out_data.blue_out);
						mismatch_cnt++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pixel_q.size() != 0 || in_valid || dithered_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_SHIFT_COUNT)
			step_log2 = int'(val[SHIFT_BITS-1:0]);
		else
			row_len = int'(val[WIDTH_BITS-1:0]);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// a wider row would read line store columns never written: restart the frame
	task automatic start_phase(input int shift_val, input int width_val, input int gap,
		input int stall);
		int new_w;
		wait_idle();
		gap_max = gap;
		stall_pct = stall;
		cfg_write(REG_SHIFT_COUNT,
			CFG_BITS'(($urandom_range(127) << SHIFT_BITS) | shift_val));
		cfg_write(REG_LINE_WIDTH, CFG_BITS'(width_val));
		new_w = eff_width(width_val);
		fresh_frame = (new_w > gen_width);
		gen_width = new_w;
	endtask

	task automatic add_pixel(input int r, input int g, input int b, input bit fs);
		px_in_t p;
		p.red = 8'(r);
		p.green = 8'(g);
		p.blue = 8'(b);
		p.frame_start = fs | fresh_frame;
		fresh_frame = 1'b0;
		pixel_q.insert(pixel_q.size(), p);
	endtask

	function automatic int rand_chan();
		case ($urandom_range(7))
			0: return 0;
			1: return 255;
			default: return $urandom_range(255);
		endcase
	endfunction

	initial begin
		int n;
		int w;
		int gaps [4];
		int stalls [3];
		gaps = '{0, 0, 3, 8};
		stalls = '{0, 30, 65};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		start_phase(4, 3, 0, 0);
		add_pixel(255, 0, 255, 1);
		add_pixel(0, 255, 0, 0);
		add_pixel(128, 127, 1, 0);
		add_pixel(255, 255, 255, 0);
		add_pixel(0, 0, 0, 0);
		add_pixel(15, 16, 17, 0);
		add_pixel(255, 255, 255, 0);

		start_phase(MAX_SHIFT, 2, 2, 40);
		add_pixel(255, 255, 255, 1);
		add_pixel(200, 128, 127, 0);
		add_pixel(255, 255, 255, 0);
		add_pixel(255, 255, 255, 0);

		// step above the maximum, zero width
		start_phase(15, 0, 0, 50);
		add_pixel(130, 129, 128, 0);
		add_pixel(130, 129, 128, 0);
		add_pixel(255, 1, 254, 0);

		start_phase(0, 5, 1, 0);
		for (int i = 0; i < 8; i++)
			add_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);

		// narrower row while mid-row: column clamps to the last
		start_phase(3, 2, 0, 0);
		add_pixel(250, 5, 129, 0);
		add_pixel(255, 255, 0, 0);
		add_pixel(100, 200, 37, 0);

		for (int ph = 0; ph < 10; ph++) begin
			w = ($urandom_range(4) == 0) ? $urandom_range(48) : $urandom_range(12, 1);
			start_phase($urandom_range(15), w, gaps[$urandom_range(3)],
				stalls[$urandom_range(2)]);
			n = $urandom_range(70, 40);
			for (int i = 0; i < n; i++)
				add_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(63) == 0);
		end

		// width register above the line store size
		start_phase($urandom_range(15), $urandom_range(2047, MAX_WIDTH + 1), 3, 30);
		n = $urandom_range(60, 30);
		for (int i = 0; i < n; i++)
			add_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== nbit_color_error_diffusion_top.f =====
+incdir+src
src/ncd_pkg.sv
src/nbit_color_error_diffusion_top.sv
dv/nbit_color_error_diffusion_top_test.sv
